[src/ahtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahtc_pkg
// Shared types, codes and hex helpers for the ASCII-hex telegram checker.
// ----------------------------------------------------------------------------
package ahtc_pkg;

  // Default frame length limit, end character included
  localparam int unsigned DEF_MAX_FRAME_CHARS = 64;

  // Fixed frame layout
  localparam int unsigned MIN_FRAME_CHARS = 8;
  localparam int unsigned POS_ADDR_LO     = 2;
  localparam int unsigned POS_LEN_LO      = 4;

  // Register reset values
  localparam logic [7:0] RST_OWN_ADDRESS = 8'd0;
  localparam logic [7:0] RST_START_CHAR  = 8'd58;
  localparam logic [7:0] RST_END_CHAR    = 8'd13;

  // ASCII constants used by the hex codec
  localparam logic [7:0] ASCII_ZERO     = 8'd48;
  localparam logic [7:0] ASCII_NINE     = 8'd57;
  localparam logic [7:0] ASCII_ALPHA_GAP = 8'd7;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDRESS = 2'd0,
    REG_START_CHAR  = 2'd1,
    REG_END_CHAR    = 2'd2
  } cfg_reg_e;

  // Result kinds
  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } result_kind_e;

  // End-of-frame status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_START    = 3'd1,
    ST_BAD_LENGTH   = 3'd2,
    ST_WRONG_ADDR   = 3'd3,
    ST_BAD_CHECKSUM = 3'd4,
    ST_TOO_SHORT    = 3'd5,
    ST_OVERLONG     = 3'd6
  } frame_status_e;

  // Digit value of one uppercase hex character; non-hex characters are not rejected
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - ASCII_ZERO;
    if ((d > 8'd9) && !d[7]) begin
      d = d - ASCII_ALPHA_GAP;
    end
    return d;
  endfunction

  // Byte from a high and a low hex character
  function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] vh;
    logic [7:0] vl;
    vh = hex_value(hi);
    vl = hex_value(lo);
    return {vh[3:0], 4'b0000} + vl;
  endfunction

  // Uppercase hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    logic [7:0] c;
    c = {4'b0000, nibble} + ASCII_ZERO;
    if (c > ASCII_NINE) begin
      c = c + ASCII_ALPHA_GAP;
    end
    return c;
  endfunction

endpackage

[src/ascii_hex_telegram_checker_unit.sv]
`timescale 1ns / 1ps
// Path: an accepted character is held in the input register, and its result,
// if any, moves into the result register when that register is free.
// Throughput: one character per cycle unless m_axis_tready holds the result;
// the frame counters and byte sum update in one pass per character.
// Reset: asynchronous, active low; configuration registers return to their
// defaults and the frame state is cleared, so the next character starts a new frame.
// ----------------------------------------------------------------------------
// ascii_hex_telegram_checker_unit
// Deframes ASCII-hex reply frames: emits data bytes and one status per frame.
// ----------------------------------------------------------------------------
module ascii_hex_telegram_checker_unit #(
  parameter int unsigned MAX_FRAME_CHARS = ahtc_pkg::DEF_MAX_FRAME_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_wr_en_i,
  input  logic [ahtc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i,
  // received characters
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_char
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [7:0] data_byte, [10:8] frame_status
  output logic                          m_axis_tuser   // [0] result_kind
);
  import ahtc_pkg::*;

  // count saturates at MAX_FRAME_CHARS + 1; total adds the end character
  localparam int unsigned CW   = $clog2(MAX_FRAME_CHARS + 2);
  localparam int unsigned TW   = CW + 1;
  localparam int unsigned CMPW = (TW > 8) ? TW : 8;

  // configuration registers
  logic [7:0] own_address_q, start_char_q, end_char_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;

  // frame state
  logic [CW-1:0] char_count_q, char_count_d;
  logic [7:0]    char_sum_q, char_sum_d;
  logic [7:0]    prev0_q, prev0_d, prev1_q, prev1_d;
  logic [7:0]    first_digit_q, first_digit_d;
  logic          start_matched_q, start_matched_d;
  logic [7:0]    recv_addr_q, recv_addr_d;
  logic [7:0]    length_field_q, length_field_d;
  logic [7:0]    data_emitted_q, data_emitted_d;

  // result register
  logic          out_valid_q;
  result_kind_e  out_kind_q, res_kind;
  logic [7:0]    out_byte_q, res_byte;
  frame_status_e out_status_q, res_status;
  logic          res_valid;

  logic          advance;
  logic [TW-1:0] total;
  logic [TW-1:0] half_len;
  logic [7:0]    pair_byte;
  logic [7:0]    sum_body;

  // move the held character into the result stage when it is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign total     = {1'b0, char_count_q} + TW'(1);
  assign half_len  = (total - TW'(MIN_FRAME_CHARS)) >> 1;
  assign pair_byte = decode_pair(first_digit_q, in_char_q);
  assign sum_body  = char_sum_q - prev0_q - prev1_q;

  // per-character update of frame state and result
  always_comb begin
    char_count_d    = char_count_q;
    char_sum_d      = char_sum_q + in_char_q;
    prev0_d         = prev1_q;
    prev1_d         = in_char_q;
    first_digit_d   = first_digit_q;
    start_matched_d = start_matched_q;
    recv_addr_d     = recv_addr_q;
    length_field_d  = length_field_q;
    data_emitted_d  = data_emitted_q;
    res_valid       = 1'b0;
    res_kind        = KIND_DATA;
    res_byte        = 8'd0;
    res_status      = ST_OK;

    if (char_count_q <= CW'(MAX_FRAME_CHARS)) begin
      char_count_d = char_count_q + CW'(1);
    end

    if (in_char_q == end_char_q) begin
      // end of frame: report status in priority order, then clear
      res_valid = 1'b1;
      res_kind  = KIND_STATUS;
      if (total > TW'(MAX_FRAME_CHARS)) begin
        res_status = ST_OVERLONG;
      end else if (total < TW'(MIN_FRAME_CHARS)) begin
        res_status = ST_TOO_SHORT;
      end else if (!start_matched_q) begin
        res_status = ST_BAD_START;
      end else if (CMPW'(length_field_q) != CMPW'(half_len)) begin
        res_status = ST_BAD_LENGTH;
      end else if (recv_addr_q != own_address_q) begin
        res_status = ST_WRONG_ADDR;
      end else if ((hex_char(sum_body[7:4]) != prev0_q) ||
                   (hex_char(sum_body[3:0]) != prev1_q)) begin
        res_status = ST_BAD_CHECKSUM;
      end
      char_count_d    = '0;
      char_sum_d      = 8'd0;
      prev0_d         = 8'd0;
      prev1_d         = 8'd0;
      first_digit_d   = 8'd0;
      start_matched_d = 1'b0;
      recv_addr_d     = 8'd0;
      length_field_d  = 8'd0;
      data_emitted_d  = 8'd0;
    end else if (char_count_q < CW'(MAX_FRAME_CHARS)) begin
      if (char_count_q == '0) begin
        start_matched_d = (in_char_q == start_char_q);
      end else if (char_count_q[0]) begin
        first_digit_d = in_char_q;
      end else if (char_count_q == CW'(POS_ADDR_LO)) begin
        recv_addr_d = pair_byte;
      end else if (char_count_q == CW'(POS_LEN_LO)) begin
        length_field_d = pair_byte;
      end else if (data_emitted_q < length_field_q) begin
        // emit data byte while the length field allows
        data_emitted_d = data_emitted_q + 8'd1;
        res_valid      = 1'b1;
        res_byte       = pair_byte;
      end
    end
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= RST_OWN_ADDRESS;
      start_char_q  <= RST_START_CHAR;
      end_char_q    <= RST_END_CHAR;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        REG_OWN_ADDRESS: own_address_q <= cfg_wdata_i;
        REG_START_CHAR:  start_char_q  <= cfg_wdata_i;
        REG_END_CHAR:    end_char_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // hold the accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  // advance frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q    <= '0;
      char_sum_q      <= 8'd0;
      prev0_q         <= 8'd0;
      prev1_q         <= 8'd0;
      first_digit_q   <= 8'd0;
      start_matched_q <= 1'b0;
      recv_addr_q     <= 8'd0;
      length_field_q  <= 8'd0;
      data_emitted_q  <= 8'd0;
    end else if (advance) begin
      char_count_q    <= char_count_d;
      char_sum_q      <= char_sum_d;
      prev0_q         <= prev0_d;
      prev1_q         <= prev1_d;
      first_digit_q   <= first_digit_d;
      start_matched_q <= start_matched_d;
      recv_addr_q     <= recv_addr_d;
      length_field_q  <= length_field_d;
      data_emitted_q  <= data_emitted_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_kind_q   <= res_kind;
      out_byte_q   <= res_byte;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_status_q, out_byte_q};
  assign m_axis_tuser  = out_kind_q;

endmodule
